FILE: sv/ccd_pkg.sv
// ---------------------------------------------------------------------------
// ccd_pkg
// Shared types, constants and the CRC-16 byte update for the COBS deframer.
// ---------------------------------------------------------------------------
package ccd_pkg;

    localparam int RX_BUFFER_BYTES  = 128;
    localparam int MAX_PACKET_BYTES = 64;
    localparam int MAX_REGISTERED   = 8;
    localparam int MAX_ENCODED      = MAX_PACKET_BYTES + MAX_PACKET_BYTES / 254 + 1;
    localparam int STORE_BYTES      = MAX_PACKET_BYTES + MAX_PACKET_BYTES / 254 + 2;
    localparam int STORE_ADDR_W     = $clog2(STORE_BYTES);
    localparam int ENC_W            = $clog2(RX_BUFFER_BYTES + 1);
    localparam int MIN_DECODED      = 3;
    localparam int CRC_BYTES        = 2;

    localparam logic [7:0]  DELIM    = 8'h00;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [1:0] {
        CFG_CRC_INIT = 2'd0,
        CFG_TYPE_IDS = 2'd1,
        CFG_REG_CNT  = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_REJ = 2'd1,
        ST_UNK = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        A_PLEN  = 2'd0,
        A_PLEN1 = 2'd1,
        A_NEXT  = 2'd2,
        A_IDX   = 2'd3
    } t_addr_sel;

    typedef struct packed {
        logic      take_byte;
        t_addr_sel addr_sel;
        logic      idx_clear;
        logic      cap_lo;
        logic      cap_hi;
        logic      crc_step;
        logic      match_cap;
        logic      out_load;
        t_status   out_status;
        logic      idx_inc;
        logic      err_inc;
        logic      frame_clear;
    } t_dp_cmd;

    typedef struct packed {
        logic nonempty;
        logic frame_bad;
        logic idx_last;
        logic crc_ok;
        logic type_found;
        logic out_free;
    } t_dp_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: sv/ccd_ram.sv
// ---------------------------------------------------------------------------
// ccd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ccd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/ccd_ctrl.sv
// ---------------------------------------------------------------------------
// ccd_ctrl
// Frame controller: collects bytes, then checks, CRCs and emits a frame.
// ---------------------------------------------------------------------------
module ccd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    input  logic [7:0]        i_rx_byte,
    output logic              o_rx_stall,
    input  ccd_pkg::t_dp_stat i_stat,
    output ccd_pkg::t_dp_cmd  o_cmd
);
    import ccd_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_CHECK   = 10'b0000000010,
        S_CRCLO   = 10'b0000000100,
        S_CRCHI   = 10'b0000001000,
        S_CRC     = 10'b0000010000,
        S_MATCH   = 10'b0000100000,
        S_EMIT_RD = 10'b0001000000,
        S_EMIT_WR = 10'b0010000000,
        S_REJ     = 10'b0100000000,
        S_UNK     = 10'b1000000000
    } t_state;

    t_state  r_state, n_state;
    t_dp_cmd cmd;
    logic    rx_acc;

    assign o_rx_stall = (r_state != S_IDLE);
    assign rx_acc     = i_rx_valid && (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.addr_sel   = A_IDX;
        cmd.out_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (rx_acc) begin
                    if (i_rx_byte != DELIM) begin
                        cmd.take_byte = 1'b1;
                    end else if (i_stat.nonempty) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                cmd.addr_sel  = A_PLEN;
                cmd.idx_clear = 1'b1;
                n_state       = i_stat.frame_bad ? S_REJ : S_CRCLO;
            end
            S_CRCLO: begin
                cmd.addr_sel = A_PLEN1;
                cmd.cap_lo   = 1'b1;
                n_state      = S_CRCHI;
            end
            S_CRCHI: begin
                cmd.cap_hi = 1'b1;
                n_state    = S_CRC;
            end
            S_CRC: begin
                cmd.addr_sel = A_NEXT;
                cmd.crc_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                cmd.match_cap = 1'b1;
                if (!i_stat.crc_ok) begin
                    n_state = S_REJ;
                end else if (i_stat.type_found) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_UNK;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                // hold the read address until the output slot frees up
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.idx_inc  = 1'b1;
                    if (i_stat.idx_last) begin
                        cmd.frame_clear = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_REJ: begin
                cmd.out_status = ST_REJ;
                if (i_stat.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.err_inc     = 1'b1;
                    cmd.frame_clear = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_UNK: begin
                cmd.out_status = ST_UNK;
                if (i_stat.out_free) begin
                    cmd.out_load    = 1'b1;
                    cmd.frame_clear = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: sv/ccd_dp.sv
// ---------------------------------------------------------------------------
// ccd_dp
// Deframer datapath: COBS decode, frame store, CRC, type match, result register.
// ---------------------------------------------------------------------------
module ccd_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    input  logic [7:0]        i_rx_byte,
    input  ccd_pkg::t_dp_cmd  i_cmd,
    output ccd_pkg::t_dp_stat o_stat,
    input  logic              i_res_stall,
    output logic              o_res_valid,
    output logic [1:0]        o_frame_status,
    output logic [2:0]        o_match_index,
    output logic [7:0]        o_payload_byte,
    output logic [5:0]        o_payload_length,
    output logic              o_last_of_frame,
    output logic [31:0]       o_error_total,
    output logic [31:0]       o_overflow_total
);
    import ccd_pkg::*;

    // configuration
    logic [15:0] r_crc_init;
    logic [63:0] r_type_ids;
    logic [3:0]  r_reg_cnt;

    // frame collection
    logic [ENC_W-1:0]        r_enc;
    logic [STORE_ADDR_W-1:0] r_dec;
    logic [7:0]              r_run;
    logic                    r_run_full;
    logic                    r_malformed;
    logic [31:0]             r_err;
    logic [31:0]             r_ovf;

    // frame check
    logic [STORE_ADDR_W-1:0] r_idx;
    logic [7:0]              r_rx_lo;
    logic [7:0]              r_rx_hi;
    logic [15:0]             r_crc;
    logic [7:0]              r_type;
    logic [2:0]              r_match;

    // result register
    logic        r_out_valid;
    t_status     r_out_status;
    logic [2:0]  r_out_idx;
    logic [7:0]  r_out_byte;
    logic [5:0]  r_out_len;
    logic        r_out_last;
    logic [31:0] r_out_err;
    logic [31:0] r_out_ovf;

    logic [ENC_W-1:0]        enc_n;
    logic                    enc_full;
    logic                    in_range;
    logic                    app_zero;
    logic                    app_data;
    logic                    room;
    logic                    ram_we;
    logic [7:0]              ram_wdata;
    logic [STORE_ADDR_W-1:0] plen_a;
    logic [STORE_ADDR_W-1:0] raddr;
    logic [7:0]              rdata;
    logic [3:0]              n_eff;
    logic                    found;
    logic [2:0]              found_idx;
    logic                    out_free;

    assign enc_full = (r_enc >= ENC_W'(RX_BUFFER_BYTES));
    assign enc_n    = r_enc + ENC_W'(1);
    assign in_range = (enc_n <= ENC_W'(MAX_ENCODED));
    assign app_zero = (r_run == 8'd0) && (enc_n > ENC_W'(1)) && !r_run_full;
    assign app_data = (r_run != 8'd0);
    assign room     = (r_dec < STORE_ADDR_W'(STORE_BYTES));
    assign ram_we   = i_cmd.take_byte && !enc_full && in_range && (app_zero || app_data) && room;
    assign ram_wdata = app_data ? i_rx_byte : 8'h00;

    assign plen_a = r_dec - STORE_ADDR_W'(CRC_BYTES);

    always_comb begin
        case (i_cmd.addr_sel)
            A_PLEN:  raddr = plen_a;
            A_PLEN1: raddr = plen_a + STORE_ADDR_W'(1);
            A_NEXT:  raddr = r_idx + STORE_ADDR_W'(1);
            A_IDX:   raddr = r_idx;
            default: raddr = r_idx;
        endcase
    end

    ccd_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_dec),
        .i_wdata (ram_wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // first registered id that matches the type byte
    always_comb begin
        n_eff     = (r_reg_cnt > 4'(MAX_REGISTERED)) ? 4'(MAX_REGISTERED) : r_reg_cnt;
        found     = 1'b0;
        found_idx = 3'd0;
        for (int i = MAX_REGISTERED - 1; i >= 0; i--) begin
            if ((4'(i) < n_eff) && (r_type_ids[8*i +: 8] == r_type)) begin
                found     = 1'b1;
                found_idx = 3'(i);
            end
        end
    end

    assign out_free = !r_out_valid || !i_res_stall;

    assign o_stat.nonempty   = (r_enc != '0);
    assign o_stat.frame_bad  = (r_enc > ENC_W'(MAX_ENCODED)) || (r_run != 8'd0) || r_malformed
                               || (r_dec > STORE_ADDR_W'(MAX_PACKET_BYTES))
                               || (r_dec < STORE_ADDR_W'(MIN_DECODED));
    assign o_stat.idx_last   = (r_idx == plen_a - STORE_ADDR_W'(1));
    assign o_stat.crc_ok     = (r_crc == {r_rx_hi, r_rx_lo});
    assign o_stat.type_found = found;
    assign o_stat.out_free   = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_init <= 16'hFFFF;
            r_type_ids <= '0;
            r_reg_cnt  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CRC_INIT: r_crc_init <= i_cfg_data[15:0];
                CFG_TYPE_IDS: r_type_ids <= i_cfg_data;
                CFG_REG_CNT:  r_reg_cnt  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc       <= '0;
            r_dec       <= '0;
            r_run       <= '0;
            r_run_full  <= 1'b0;
            r_malformed <= 1'b0;
            r_err       <= '0;
            r_ovf       <= '0;
        end else begin
            if (i_cmd.take_byte) begin
                if (enc_full) begin
                    r_ovf <= r_ovf + 32'd1;
                end else begin
                    r_enc <= enc_n;
                    if (in_range) begin
                        if (app_zero || app_data) begin
                            if (room) begin
                                r_dec <= r_dec + STORE_ADDR_W'(1);
                            end else begin
                                r_malformed <= 1'b1;
                            end
                        end
                        if (r_run == 8'd0) begin
                            r_run      <= i_rx_byte - 8'd1;
                            r_run_full <= (i_rx_byte == 8'hFF);
                        end else begin
                            r_run <= r_run - 8'd1;
                        end
                    end
                end
            end
            if (i_cmd.err_inc) begin
                r_err <= r_err + 32'd1;
            end
            if (i_cmd.frame_clear) begin
                r_enc       <= '0;
                r_dec       <= '0;
                r_run       <= '0;
                r_run_full  <= 1'b0;
                r_malformed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_clear || i_cmd.match_cap) begin
            r_idx <= '0;
        end else if (i_cmd.crc_step || i_cmd.idx_inc) begin
            r_idx <= r_idx + STORE_ADDR_W'(1);
        end
        if (i_cmd.cap_lo) begin
            r_rx_lo <= rdata;
        end
        if (i_cmd.cap_hi) begin
            r_rx_hi <= rdata;
            r_crc   <= r_crc_init;
        end
        if (i_cmd.crc_step) begin
            r_crc <= crc_byte(r_crc, rdata);
            if (r_idx == '0) begin
                r_type <= rdata;
            end
        end
        if (i_cmd.match_cap) begin
            r_match <= found_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_cmd.out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_ovf    <= r_ovf;
            r_out_err    <= i_cmd.err_inc ? r_err + 32'd1 : r_err;
            case (i_cmd.out_status)
                ST_OK: begin
                    r_out_idx  <= r_match;
                    r_out_byte <= rdata;
                    r_out_len  <= plen_a[5:0];
                    r_out_last <= o_stat.idx_last;
                end
                ST_UNK: begin
                    r_out_idx  <= '0;
                    r_out_byte <= '0;
                    r_out_len  <= plen_a[5:0];
                    r_out_last <= 1'b1;
                end
                default: begin
                    r_out_idx  <= '0;
                    r_out_byte <= '0;
                    r_out_len  <= '0;
                    r_out_last <= 1'b1;
                end
            endcase
        end
    end

    assign o_res_valid      = r_out_valid;
    assign o_frame_status   = r_out_status;
    assign o_match_index    = r_out_idx;
    assign o_payload_byte   = r_out_byte;
    assign o_payload_length = r_out_len;
    assign o_last_of_frame  = r_out_last;
    assign o_error_total    = r_out_err;
    assign o_overflow_total = r_out_ovf;
endmodule

FILE: sv/cobs_crc_packet_deframer.sv
// ---------------------------------------------------------------------------
// cobs_crc_packet_deframer
// COBS deframer with CRC-16 check and registered packet-type dispatch.
// ---------------------------------------------------------------------------
// Data bytes: one per cycle, no result; the frame store takes one write a cycle.
// Delimiter: input stalls while a non-empty frame is checked and reported; the
//   CRC pass reads the store one byte a cycle, and emission of a matched frame
//   does a store read, then a result register load, for each payload byte, plus
//   any output stall. Unknown type, bad CRC, length or COBS reject: one result.
// Reset (synchronous, active low) clears counters, frame state, control and
//   sets the CRC start value to 0xFFFF; the frame store is not cleared.
module cobs_crc_packet_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [1:0]  o_frame_status,
    output logic [2:0]  o_match_index,
    output logic [7:0]  o_payload_byte,
    output logic [5:0]  o_payload_length,
    output logic        o_last_of_frame,
    output logic [31:0] o_error_total,
    output logic [31:0] o_overflow_total
);
    import ccd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ccd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .i_rx_byte  (i_rx_byte),
        .o_rx_stall (o_rx_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ccd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_rx_byte        (i_rx_byte),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_res_stall      (i_res_stall),
        .o_res_valid      (o_res_valid),
        .o_frame_status   (o_frame_status),
        .o_match_index    (o_match_index),
        .o_payload_byte   (o_payload_byte),
        .o_payload_length (o_payload_length),
        .o_last_of_frame  (o_last_of_frame),
        .o_error_total    (o_error_total),
        .o_overflow_total (o_overflow_total)
    );

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_status != ST_OK) |-> o_last_of_frame)
        else $error("reject or discard result not marked last");

    a_reject_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_status == ST_REJ) |-> (o_payload_length == 6'd0))
        else $error("rejected frame carries a length");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_status == ST_OK) |-> (o_payload_length != 6'd0))
        else $error("payload byte with zero frame length");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load || cmd.crc_step) |-> o_rx_stall)
        else $error("input taken while a frame is in flight");
endmodule

FILE: tb/deframer_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// deframer_checker
// Watches the configuration port and both channels of the deframer, predicts
// the result stream per delimiter and compares every result field by field.
// ---------------------------------------------------------------------------
module deframer_checker
    import ccd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_rx_valid,
    input  logic        i_rx_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [1:0]  i_frame_status,
    input  logic [2:0]  i_match_index,
    input  logic [7:0]  i_payload_byte,
    input  logic [5:0]  i_payload_length,
    input  logic        i_last_of_frame,
    input  logic [31:0] i_error_total,
    input  logic [31:0] i_overflow_total,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  idx;
        logic [7:0]  pbyte;
        logic [5:0]  plen;
        logic        last;
        logic [31:0] err;
        logic [31:0] ovf;
    } t_frame_res;

    t_frame_res expected_q[$];

    logic [15:0] crc_init;
    logic [63:0] type_ids;
    logic [3:0]  type_cnt;

    int unsigned enc_cnt, dec_cnt, run_left;
    bit          run_full, malformed;
    logic [7:0]  dstore[STORE_BYTES];
    logic [31:0] err_cnt, ovf_cnt;

    assign o_pending = expected_q.size();

    function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
        c = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    task automatic push_res(logic [1:0] st, logic [2:0] ix, logic [7:0] pb,
                            logic [5:0] pl, logic lst);
        t_frame_res r;
        r.status = st; r.idx = ix; r.pbyte = pb; r.plen = pl; r.last = lst;
        r.err = err_cnt; r.ovf = ovf_cnt;
        expected_q.push_back(r);
    endtask

    task automatic append_dec(logic [7:0] b);
        if (dec_cnt < STORE_BYTES) begin
            dstore[dec_cnt] = b;
            dec_cnt++;
        end else begin
            malformed = 1;
        end
    endtask

    task automatic predict_byte(logic [7:0] b);
        int unsigned plen, n;
        logic [15:0] crc, rx_crc;
        bit found;
        if (b != DELIM) begin
            if (enc_cnt >= RX_BUFFER_BYTES) begin
                ovf_cnt++;
                return;
            end
            enc_cnt++;
            if (enc_cnt > MAX_ENCODED) return;
            if (run_left == 0) begin
                if (enc_cnt > 1 && !run_full) append_dec(8'h00);
                run_left = b - 1;
                run_full = (b == 8'hFF);
            end else begin
                append_dec(b);
                run_left--;
            end
            return;
        end
        if (enc_cnt == 0) return;
        if (enc_cnt > MAX_ENCODED || run_left != 0 || malformed || dec_cnt == 0 ||
            dec_cnt > MAX_PACKET_BYTES || dec_cnt < MIN_DECODED) begin
            err_cnt++;
            push_res(ST_REJ, 3'd0, 8'd0, 6'd0, 1'b1);
        end else begin
            plen = dec_cnt - CRC_BYTES;
            rx_crc = {dstore[plen+1], dstore[plen]};
            crc = crc_init;
            for (int i = 0; i < plen; i++) crc = crc16_update(crc, dstore[i]);
            if (crc != rx_crc) begin
                err_cnt++;
                push_res(ST_REJ, 3'd0, 8'd0, 6'd0, 1'b1);
            end else begin
                n = (type_cnt > MAX_REGISTERED) ? MAX_REGISTERED : type_cnt;
                found = 0;
                for (int i = 0; i < n && !found; i++) begin
                    if (type_ids[8*i +: 8] == dstore[0]) begin
                        found = 1;
                        for (int j = 0; j < plen; j++)
                            push_res(ST_OK, 3'(i), dstore[j], 6'(plen), (j + 1 == plen));
                    end
                end
                if (!found) push_res(ST_UNK, 3'd0, 8'd0, 6'(plen), 1'b1);
            end
        end
        enc_cnt = 0; dec_cnt = 0; run_left = 0; run_full = 0; malformed = 0;
    endtask

    always @(posedge i_clk) begin
        t_frame_res act, exp_r;
        if (!i_rst_n) begin
            crc_init = 16'hFFFF; type_ids = '0; type_cnt = '0;
            enc_cnt = 0; dec_cnt = 0; run_left = 0; run_full = 0; malformed = 0;
            err_cnt = '0; ovf_cnt = '0;
            expected_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRC_INIT: crc_init = i_cfg_data[15:0];
                    CFG_TYPE_IDS: type_ids = i_cfg_data;
                    CFG_REG_CNT:  type_cnt = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                act = {i_frame_status, i_match_index, i_payload_byte, i_payload_length,
                       i_last_of_frame, i_error_total, i_overflow_total};
                if (expected_q.size() == 0) begin
                    if (o_fail_count < 10) $display("unexpected result %h", act);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (act !== exp_r) begin
                        if (o_fail_count < 10)
                            $display("mismatch exp st=%0d ix=%0d b=%h len=%0d last=%0b",
                                exp_r.status, exp_r.idx, exp_r.pbyte, exp_r.plen,
                                exp_r.last, " err=%0d ovf=%0d", exp_r.err, exp_r.ovf,
                                " act st=%0d ix=%0d b=%h len=%0d last=%0b",
                                act.status, act.idx, act.pbyte, act.plen, act.last,
                                " err=%0d ovf=%0d", act.err, act.ovf);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_rx_valid && !i_rx_stall) predict_byte(i_rx_byte);
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives COBS/CRC frames, noise and register settings into the deframer;
// the checker predicts and compares, and this module reports the verdict.
// ---------------------------------------------------------------------------
module tb;
    import ccd_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_idx = CFG_CRC_INIT;
    logic [63:0] cfg_data = '0;
    logic        rx_valid = 0;
    logic        rx_stall;
    logic [7:0]  rx_byte = '0;
    logic        res_valid;
    logic        res_stall = 0;
    logic [1:0]  frame_status;
    logic [2:0]  match_index;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_length;
    logic        last_of_frame;
    logic [31:0] error_total, overflow_total;
    int          fail_count, pending;

    int          cycle_cnt = 0;
    bit          quiet_mode = 0;
    bit          hold_off = 0;
    logic [15:0] cur_crc_init = 16'hFFFF;
    logic [63:0] cur_ids = '0;
    logic [7:0]  link_q[$];
    logic [7:0]  raw[$];

    always #5 i_clk = ~i_clk;

    cobs_crc_packet_deframer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_rx_valid(rx_valid), .o_rx_stall(rx_stall), .i_rx_byte(rx_byte),
        .o_res_valid(res_valid), .i_res_stall(res_stall),
        .o_frame_status(frame_status), .o_match_index(match_index),
        .o_payload_byte(payload_byte), .o_payload_length(payload_length),
        .o_last_of_frame(last_of_frame), .o_error_total(error_total),
        .o_overflow_total(overflow_total)
    );

    deframer_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_rx_valid(rx_valid), .i_rx_stall(rx_stall), .i_rx_byte(rx_byte),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_frame_status(frame_status), .i_match_index(match_index),
        .i_payload_byte(payload_byte), .i_payload_length(payload_length),
        .i_last_of_frame(last_of_frame), .i_error_total(error_total),
        .i_overflow_total(overflow_total),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 900000) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, none in quiet mode, or a long hold-off when asked.
    always @(posedge i_clk) begin
        if (hold_off) res_stall <= 1;
        else if (quiet_mode) res_stall <= 0;
        else res_stall <= ($urandom_range(99) < 11);
    end

    function automatic logic [15:0] crc_calc(logic [15:0] init);
        logic [15:0] c;
        c = init;
        foreach (raw[i]) begin
            c = c ^ {raw[i], 8'h00};
            for (int k = 0; k < 8; k++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

    // COBS-encode raw[] onto the link queue, followed by a delimiter.
    task automatic cobs_push();
        logic [7:0] blk[$];
        foreach (raw[i]) begin
            if (raw[i] == 8'h00) begin
                link_q.push_back(8'(blk.size() + 1));
                foreach (blk[j]) link_q.push_back(blk[j]);
                blk.delete();
            end else begin
                blk.push_back(raw[i]);
                if (blk.size() == 254) begin
                    link_q.push_back(8'hFF);
                    foreach (blk[j]) link_q.push_back(blk[j]);
                    blk.delete();
                end
            end
        end
        link_q.push_back(8'(blk.size() + 1));
        foreach (blk[j]) link_q.push_back(blk[j]);
        link_q.push_back(8'h00);
    endtask

    // Build a frame: type, body, CRC (optionally corrupted), then encode.
    task automatic make_frame(logic [7:0] ftype, int blen, int zero_pct, bit bad_crc);
        logic [15:0] c;
        raw.delete();
        raw.push_back(ftype);
        for (int i = 0; i < blen; i++)
            raw.push_back(($urandom_range(99) < zero_pct) ? 8'h00 : 8'($urandom_range(255)));
        c = crc_calc(cur_crc_init);
        if (bad_crc) c ^= 16'h0001 << $urandom_range(15);
        raw.push_back(c[7:0]);
        raw.push_back(c[15:8]);
        cobs_push();
    endtask

    task automatic send_all();
        while (link_q.size() > 0) begin
            if (!quiet_mode && $urandom_range(99) < 11) begin
                rx_valid <= 0;
                @(posedge i_clk);
            end else begin
                rx_valid <= 1;
                rx_byte  <= link_q.pop_front();
                @(posedge i_clk);
                while (rx_stall) @(posedge i_clk);
            end
        end
        rx_valid <= 0;
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [63:0] d);
        cfg_we <= 1; cfg_idx <= idx; cfg_data <= d;
        @(posedge i_clk);
        cfg_we <= 0;
        if (idx == CFG_CRC_INIT) cur_crc_init = d[15:0];
        if (idx == CFG_TYPE_IDS) cur_ids = d;
    endtask

    function automatic logic [7:0] pick_type();
        if ($urandom_range(99) < 80) return cur_ids[8*$urandom_range(7) +: 8];
        return 8'($urandom_range(255));
    endfunction

    task automatic random_phase(int n_frames);
        int r;
        for (int f = 0; f < n_frames; f++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                make_frame(pick_type(), ($urandom_range(9) == 0) ? $urandom_range(61)
                           : $urandom_range(8), $urandom_range(30), 0);
            end else if (r < 80) begin
                make_frame(pick_type(), $urandom_range(6), 20, 1);
            end else begin
                // noise: random bytes, some delimiters, sometimes broken runs
                repeat ($urandom_range(1, 8))
                    link_q.push_back(($urandom_range(5) == 0) ? 8'h00
                                     : 8'($urandom_range(255)));
                link_q.push_back(8'h00);
            end
            send_all();
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Reset defaults: no registered ids, so good frames are discarded.
        make_frame(8'h11, 3, 0, 0);
        make_frame(8'hFF, 0, 0, 0);
        send_all();
        drain();

        cfg_write(CFG_TYPE_IDS, 64'h8877_6655_4433_2211);
        cfg_write(CFG_REG_CNT, 64'd8);
        cfg_write(CFG_CRC_INIT, 64'h0000);
        // directed: min frame, max frame, bad CRC, short, empty, truncated run,
        // overflow, zero-laden, unknown type
        make_frame(8'h11, 0, 0, 0);
        make_frame(8'h88, 61, 0, 0);
        make_frame(8'h22, 61, 50, 0);
        make_frame(8'h33, 4, 0, 1);
        make_frame(8'h99, 2, 0, 0);
        link_q.push_back(8'h00); link_q.push_back(8'h00);
        link_q.push_back(8'h02); link_q.push_back(8'h05); link_q.push_back(8'h00);
        link_q.push_back(8'h05); link_q.push_back(8'h01); link_q.push_back(8'h00);
        link_q.push_back(8'h01); link_q.push_back(8'h01); link_q.push_back(8'h00);
        for (int i = 0; i < 140; i++) link_q.push_back(8'hFF);
        link_q.push_back(8'h00);
        send_all();
        drain();

        // type id list with duplicates and a count above the list size
        cfg_write(CFG_TYPE_IDS, 64'hFFFF_0000_AAAA_5555);
        cfg_write(CFG_REG_CNT, 64'd15);
        cfg_write(CFG_CRC_INIT, 64'hFFFF);
        random_phase(3);
        drain();

        // long receiver hold-off while frames keep coming
        hold_off = 1;
        fork
            begin
                make_frame(8'h55, 20, 10, 0);
                make_frame(8'hAA, 20, 10, 0);
                send_all();
            end
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
        join
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            cfg_write(CFG_CRC_INIT, 64'($urandom_range(16'hFFFF)));
            cfg_write(CFG_TYPE_IDS, {$urandom, $urandom});
            cfg_write(CFG_REG_CNT, (ph == 0) ? 64'd0 : 64'($urandom_range(15)));
            quiet_mode = (ph == 2);
            random_phase((ph == 2) ? 5 : 1);
            drain();
        end
        quiet_mode = 0;

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/ccd_pkg.sv
sv/ccd_ram.sv
sv/ccd_ctrl.sv
sv/ccd_dp.sv
sv/cobs_crc_packet_deframer.sv
tb/deframer_checker.sv
tb/tb.sv
